@@ rtl/hsr_pkg.sv @@
// Shared types and constants for the hue sector to RGB converter.
// Used by every module of the block; has no dependencies of its own.
package hsr_pkg;

	// Number of hue bits taken as the fraction of the full circle.
	localparam int unsigned HUE_BITS = 16;
	// Width of the saturation, intensity and color channels.
	localparam int unsigned CHAN_W = 16;
	// Width of hue * 6: three extra bits hold the sector number.
	localparam int unsigned T_W = HUE_BITS + 3;
	// Width of the raw intensity * (1 - saturation) product.
	localparam int unsigned LOW_PROD_W = 2 * CHAN_W;
	// Width of the raw difference * fraction product.
	localparam int unsigned RAMP_PROD_W = CHAN_W + HUE_BITS;
	// Width of one packed item on either stream.
	localparam int unsigned DATA_W = 3 * CHAN_W;

	// 1.0 in Q1.15.
	localparam logic [CHAN_W-1:0] ONE_Q15 = CHAN_W'(32768);

	// Sector of the color circle; the name lists red, green, blue in order.
	typedef enum logic [2:0] {
		SEC_V_RISE_LOW = 3'd0,
		SEC_FALL_V_LOW = 3'd1,
		SEC_LOW_V_RISE = 3'd2,
		SEC_LOW_FALL_V = 3'd3,
		SEC_RISE_LOW_V = 3'd4,
		SEC_V_LOW_FALL = 3'd5
	} sector_t;

	// Payload after the first stage.
	typedef struct packed {
		sector_t             sector;
		logic [HUE_BITS-1:0] frac;
		logic [CHAN_W-1:0]   val;
		logic [CHAN_W-1:0]   one_minus_sat;
	} front_t;

	// Payload after the ramp stages, ready for channel selection.
	typedef struct packed {
		sector_t           sector;
		logic [CHAN_W-1:0] val;
		logic [CHAN_W-1:0] low;
		logic [CHAN_W-1:0] ramp;
	} ramp_t;

	// Load enables of the three ramp stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} ramp_en_t;

	// Saturate a Q1.15 value at 1.0.
	function automatic logic [CHAN_W-1:0] clamp_one(input logic [CHAN_W-1:0] v);
		logic [CHAN_W-1:0] r;
		r = (v > ONE_Q15) ? ONE_Q15 : v;
		return r;
	endfunction

endpackage

@@ rtl/hsr_front.sv @@
// First pipeline stage: clamps saturation and intensity and splits hue * 6 into sector and fraction.
// Depends on hsr_pkg.
module hsr_front (
	input  logic                         clk,
	input  logic                         en,
	input  logic [hsr_pkg::CHAN_W-1:0]   hue,
	input  logic [hsr_pkg::CHAN_W-1:0]   saturation,
	input  logic [hsr_pkg::CHAN_W-1:0]   intensity,
	output hsr_pkg::front_t              front_s1
);

	logic [hsr_pkg::HUE_BITS-1:0] hue_w;
	logic [hsr_pkg::T_W-1:0]      t;
	logic [hsr_pkg::CHAN_W-1:0]   sat_c;

	// Hue times six as a sum of two shifts; the top three bits are the sector.
	always_comb begin
		hue_w = hue[hsr_pkg::HUE_BITS-1:0];
		t = (hsr_pkg::T_W'(hue_w) << 2) + (hsr_pkg::T_W'(hue_w) << 1);
		sat_c = hsr_pkg::clamp_one(saturation);
	end

	// Stage register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (en) begin
			front_s1.sector        <= hsr_pkg::sector_t'(t[hsr_pkg::T_W-1:hsr_pkg::HUE_BITS]);
			front_s1.frac          <= t[hsr_pkg::HUE_BITS-1:0];
			front_s1.val           <= hsr_pkg::clamp_one(intensity);
			front_s1.one_minus_sat <= hsr_pkg::ONE_Q15 - sat_c;
		end
	end

endmodule

@@ rtl/hsr_ramp.sv @@
// Stages two to four: the low level, the span above it, and the scaled ramp.
// Depends on hsr_pkg; fed by hsr_front.
module hsr_ramp (
	input  logic              clk,
	input  hsr_pkg::ramp_en_t en,
	input  hsr_pkg::front_t   front_s1,
	output hsr_pkg::ramp_t    ramp_s4
);

	hsr_pkg::sector_t               sector_s2, sector_s3;
	logic [hsr_pkg::HUE_BITS-1:0]   frac_s2, frac_s3;
	logic [hsr_pkg::CHAN_W-1:0]     val_s2, val_s3;
	logic [hsr_pkg::CHAN_W-1:0]     low_s2, low_s3;
	logic [hsr_pkg::CHAN_W-1:0]     span_s3;
	logic [hsr_pkg::LOW_PROD_W-1:0] low_prod;
	logic [hsr_pkg::RAMP_PROD_W-1:0] ramp_prod;

	// Intensity times (1 - saturation), truncated back to Q1.15.
	assign low_prod = hsr_pkg::LOW_PROD_W'(front_s1.val) *
		hsr_pkg::LOW_PROD_W'(front_s1.one_minus_sat);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= front_s1.sector;
			frac_s2   <= front_s1.frac;
			val_s2    <= front_s1.val;
			low_s2    <= low_prod[hsr_pkg::CHAN_W+14:15];
		end
	end

	// Span between the two levels; the low level never exceeds intensity.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sector_s3 <= sector_s2;
			frac_s3   <= frac_s2;
			val_s3    <= val_s2;
			low_s3    <= low_s2;
			span_s3   <= val_s2 - low_s2;
		end
	end

	// Span times the fraction within the sector, truncated.
	assign ramp_prod = hsr_pkg::RAMP_PROD_W'(span_s3) * hsr_pkg::RAMP_PROD_W'(frac_s3);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ramp_s4.sector <= sector_s3;
			ramp_s4.val    <= val_s3;
			ramp_s4.low    <= low_s3;
			ramp_s4.ramp   <= ramp_prod[hsr_pkg::RAMP_PROD_W-1:hsr_pkg::HUE_BITS];
		end
	end

endmodule

@@ rtl/hsr_mix.sv @@
// Last stage: forms the rising and falling levels and routes them to the channels.
// Depends on hsr_pkg; fed by hsr_ramp.
module hsr_mix (
	input  logic                       clk,
	input  logic                       en,
	input  hsr_pkg::ramp_t             ramp_s4,
	output logic [hsr_pkg::CHAN_W-1:0] red_s5,
	output logic [hsr_pkg::CHAN_W-1:0] green_s5,
	output logic [hsr_pkg::CHAN_W-1:0] blue_s5
);

	logic [hsr_pkg::CHAN_W-1:0] rise, fall, v, lo;
	logic [hsr_pkg::CHAN_W-1:0] r, g, b;

	// Channel selection by sector.
	always_comb begin
		v    = ramp_s4.val;
		lo   = ramp_s4.low;
		rise = lo + ramp_s4.ramp;
		fall = v - ramp_s4.ramp;
		case (ramp_s4.sector)
			hsr_pkg::SEC_V_RISE_LOW: begin r = v;    g = rise; b = lo;   end
			hsr_pkg::SEC_FALL_V_LOW: begin r = fall; g = v;    b = lo;   end
			hsr_pkg::SEC_LOW_V_RISE: begin r = lo;   g = v;    b = rise; end
			hsr_pkg::SEC_LOW_FALL_V: begin r = lo;   g = fall; b = v;    end
			hsr_pkg::SEC_RISE_LOW_V: begin r = rise; g = lo;   b = v;    end
			default:                 begin r = v;    g = lo;   b = fall; end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			red_s5   <= r;
			green_s5 <= g;
			blue_s5  <= b;
		end
	end

endmodule

@@ rtl/hue_sector_to_rgb.sv @@
// Six-sector HSV to RGB converter, five register stages deep.
// Throughput: one item per cycle while m_axis_tready is high; a full stage holds
// while the stage after it is full and cannot pass its item on.
// The two multipliers (low level and ramp) each sit in a stage of their own.
// Reset (arst_n, asynchronous) empties the pipeline; data registers are not reset.
module hue_sector_to_rgb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// From bit 0: hue[15:0], saturation[31:16], intensity[47:32].
	input  logic [hsr_pkg::DATA_W-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// From bit 0: red[15:0], green[31:16], blue[47:32].
	output logic [hsr_pkg::DATA_W-1:0] m_axis_tdata
);

	localparam int unsigned CW = hsr_pkg::CHAN_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en5;
	hsr_pkg::ramp_en_t en_r;
	hsr_pkg::front_t   front_s1;
	hsr_pkg::ramp_t    ramp_s4;
	logic [CW-1:0]     red_s5, green_s5, blue_s5;

	// A stage loads when it is empty or its item moves on in this cycle.
	always_comb begin
		en5     = !v_s5 || m_axis_tready;
		en_r.s4 = !v_s4 || en5;
		en_r.s3 = !v_s3 || en_r.s4;
		en_r.s2 = !v_s2 || en_r.s3;
		en1     = !v_s1 || en_r.s2;
	end

	assign s_axis_tready = en1;
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {blue_s5, green_s5, red_s5};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1)     v_s1 <= s_axis_tvalid;
			if (en_r.s2) v_s2 <= v_s1;
			if (en_r.s3) v_s3 <= v_s2;
			if (en_r.s4) v_s4 <= v_s3;
			if (en5)     v_s5 <= v_s4;
		end
	end

	hsr_front u_front (
		.clk        (clk),
		.en         (en1),
		.hue        (s_axis_tdata[CW-1:0]),
		.saturation (s_axis_tdata[2*CW-1:CW]),
		.intensity  (s_axis_tdata[3*CW-1:2*CW]),
		.front_s1   (front_s1)
	);

	hsr_ramp u_ramp (
		.clk      (clk),
		.en       (en_r),
		.front_s1 (front_s1),
		.ramp_s4  (ramp_s4)
	);

	hsr_mix u_mix (
		.clk      (clk),
		.en       (en5),
		.ramp_s4  (ramp_s4),
		.red_s5   (red_s5),
		.green_s5 (green_s5),
		.blue_s5  (blue_s5)
	);

`ifndef SYNTHESIS
	// An empty first stage always takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with an empty first stage");

	// An item in stage four reaches the output register when it advances.
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en5) |=> m_axis_tvalid)
		else $error("item lost between stage four and the output");

	// Every output channel stays within 0..1.0.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (red_s5 <= hsr_pkg::ONE_Q15 && green_s5 <= hsr_pkg::ONE_Q15 &&
			blue_s5 <= hsr_pkg::ONE_Q15))
		else $error("output channel above 1.0");

	// The ramp never exceeds the span between the low level and the intensity.
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (ramp_s4.low <= ramp_s4.val &&
			ramp_s4.ramp <= ramp_s4.val - ramp_s4.low))
		else $error("ramp outside its span");
`endif

endmodule
